### src/mpsei_pkg.sv
// ----------------------------------------------------------------------------
// mpsei_pkg
// Types, constants and the display extension table for the MPEG-2 sequence
// display extension inserter.
// ----------------------------------------------------------------------------
package mpsei_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // Start code prefix and the sequence extension identifiers.
  localparam logic [7:0] ScPrefix0   = 8'h00;
  localparam logic [7:0] ScPrefix1   = 8'h00;
  localparam logic [7:0] ScPrefix2   = 8'h01;
  localparam logic [7:0] ExtStartId  = 8'hB5;
  localparam logic [3:0] SeqExtId    = 4'h1;

  localparam int unsigned HistDepth   = 4;
  localparam int unsigned SeqExtTail  = 5;
  localparam int unsigned DispExtLen  = 11;

  localparam int unsigned HistCntW    = $clog2(HistDepth + 1);
  localparam int unsigned ExtRemW     = $clog2(SeqExtTail + 1);
  localparam int unsigned InsCntW     = $clog2(DispExtLen + 1);
  localparam int unsigned InsIdxW     = $clog2(DispExtLen);

  // Fixed sequence display extension, emitted after a sequence extension.
  function automatic logic [7:0] disp_ext_byte(input logic [InsIdxW-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h00;
      4'd2:    b = 8'h01;
      4'd3:    b = 8'hB5;
      4'd4:    b = 8'h25;
      4'd5:    b = 8'h04;
      4'd6:    b = 8'h04;
      4'd7:    b = 8'h05;
      4'd8:    b = 8'h0B;
      4'd9:    b = 8'h42;
      4'd10:   b = 8'h0F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### src/mpeg2_seq_ext_inserter.sv
// ----------------------------------------------------------------------------
// mpeg2_seq_ext_inserter
// Byte-wide MPEG-2 video pass-through that appends a sequence display
// extension after every sequence extension.
// ----------------------------------------------------------------------------
// Every accepted byte leaves unchanged, one word per cycle unless the output
// stalls, through a single output register. The scanner looks for 00 00 01 B5
// followed by a byte whose top nibble is 1; once matched, the next five bytes
// complete the ten-byte sequence extension and are not scanned. After the
// tenth byte the block emits the 11-byte display extension 00 00 01 B5 25
// 04 04 05 0B 42 0F from a constant table, one byte per cycle unless the
// output stalls, and holds in_ready_o low meanwhile. A stream cut short
// inside an extension gets no insertion. out_last marks the final word
// emitted for an input word with is_last set (the last inserted byte if
// an insertion follows it), and the scanner returns to its reset state after
// that input word, so the next word begins a fresh stream. An accepted byte
// is presented at the output in the cycle after its acceptance.
module mpeg2_seq_ext_inserter
  import mpsei_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  // Scanner state
  logic [HistDepth-1:0][7:0] hist_q, hist_d;
  logic [HistCntW-1:0]       hist_cnt_q, hist_cnt_d;
  logic [ExtRemW-1:0]        ext_rem_q, ext_rem_d;

  // Output register and insertion sequencer
  logic                      out_valid_q, out_valid_d;
  out_word_t                 out_word_q, out_word_d;
  logic [InsCntW-1:0]        ins_cnt_q, ins_cnt_d;   // inserted words still to send
  logic                      ins_last_q, ins_last_d; // last inserted word ends stream

  logic in_fire, out_fire, match, insert;
  logic [InsIdxW-1:0] ins_idx;

  // Take a new word when the output register is empty or empties this cycle
  // and no insertion is pending behind it.
  assign in_ready_o = !out_valid_q || (out_ready_i && (ins_cnt_q == '0));
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // Start code followed by a sequence extension id, only on a full history.
  assign match = (hist_cnt_q == HistCntW'(HistDepth)) &&
                 (hist_q[0] == ScPrefix0) && (hist_q[1] == ScPrefix1) &&
                 (hist_q[2] == ScPrefix2) && (hist_q[3] == ExtStartId) &&
                 (in_data_i.data_byte[7:4] == SeqExtId);

  // Tenth byte of a matched extension arrives now.
  assign insert = (ext_rem_q == ExtRemW'(1));

  assign ins_idx = InsIdxW'(InsCntW'(DispExtLen) - ins_cnt_q);

  always_comb begin
    hist_d     = hist_q;
    hist_cnt_d = hist_cnt_q;
    ext_rem_d  = ext_rem_q;

    if (in_fire) begin
      if (ext_rem_q != '0) begin
        // Inside a matched extension: count down, skip scanning.
        ext_rem_d = ext_rem_q - ExtRemW'(1);
        if (insert) begin
          hist_cnt_d = '0;
        end
      end else begin
        hist_d = {in_data_i.data_byte, hist_q[HistDepth-1:1]};
        if (match) begin
          ext_rem_d  = ExtRemW'(SeqExtTail);
          hist_cnt_d = '0;
        end else if (hist_cnt_q != HistCntW'(HistDepth)) begin
          hist_cnt_d = hist_cnt_q + HistCntW'(1);
        end
      end
      // End of stream: start over.
      if (in_data_i.is_last) begin
        hist_d     = '0;
        hist_cnt_d = '0;
        ext_rem_d  = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    ins_cnt_d   = ins_cnt_q;
    ins_last_d  = ins_last_q;

    if (in_fire) begin
      // Load the passed-through byte; arm the insertion if it ends an extension.
      out_valid_d         = 1'b1;
      out_word_d.out_byte = in_data_i.data_byte;
      out_word_d.out_last = in_data_i.is_last && !insert;
      ins_cnt_d           = insert ? InsCntW'(DispExtLen) : '0;
      ins_last_d          = in_data_i.is_last;
    end else if (out_fire) begin
      if (ins_cnt_q != '0) begin
        // Advance through the display extension table.
        out_word_d.out_byte = disp_ext_byte(ins_idx);
        out_word_d.out_last = ins_last_q && (ins_cnt_q == InsCntW'(1));
        ins_cnt_d           = ins_cnt_q - InsCntW'(1);
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      hist_cnt_q  <= '0;
      ext_rem_q   <= '0;
      out_valid_q <= 1'b0;
      ins_cnt_q   <= '0;
      ins_last_q  <= 1'b0;
    end else begin
      hist_q      <= hist_d;
      hist_cnt_q  <= hist_cnt_d;
      ext_rem_q   <= ext_rem_d;
      out_valid_q <= out_valid_d;
      ins_cnt_q   <= ins_cnt_d;
      ins_last_q  <= ins_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

endmodule

### src/mpsei_checker.sv
// ----------------------------------------------------------------------------
// mpsei_checker
// Port-level checks for the sequence display extension inserter.
// ----------------------------------------------------------------------------
module mpsei_checker
  import mpsei_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // No new word enters while the output register is blocked.
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  // Every accepted word shows up at the output next cycle.
  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted word produced no output");

  // After the final word of a stream nothing remains to send.
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_data_o.out_last && !in_fire |=> !out_valid_o)
    else $error("output continued after end of stream");

endmodule

bind mpeg2_seq_ext_inserter mpsei_checker u_mpsei_checker (.*);

### bench/mpeg2_seq_ext_inserter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpeg2_seq_ext_inserter_tb
// Self-checking bench for the sequence display extension inserter. A short
// table of hand-picked words runs first. Random elementary streams follow,
// built mostly from well-formed sequence extensions with random content plus
// near misses and noise. A behavioral predictor forecasts every output word,
// and a monitor checks each one in order.
// ----------------------------------------------------------------------------
module mpeg2_seq_ext_inserter_tb;
  import mpsei_pkg::*;

  // One row of the directed table: the input word, a flag telling whether the
  // single expected output word is typed in, and that word.
  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } dir_row_t;

  localparam logic Typed = 1'b1;
  localparam logic Free  = 1'b0;
  localparam int   NumDirRows = 26;
  localparam int   RandWords  = 150;
  localparam int   HoldCycles = 80;
  localparam int   DrainCycles = 16;

  // Fixed sequence display extension that follows every sequence extension.
  localparam logic [7:0] DispBytes [DispExtLen] = '{
    8'h00, 8'h00, 8'h01, 8'hB5, 8'h25, 8'h04, 8'h04, 8'h05, 8'h0B, 8'h42, 8'h0F
  };

  // Directed words: a full extension whose tail holds a start code (and ends
  // on byte FF), a word right after the insertion, a stream cut short on the
  // matching byte, and an extension whose tenth byte ends the stream.
  localparam dir_row_t DirTab [NumDirRows] = '{
    {8'h00, 1'b0, Typed, 8'h00, 1'b0},  // first word after reset
    {8'h00, 1'b0, Free,  8'h00, 1'b0},
    {8'h01, 1'b0, Free,  8'h00, 1'b0},
    {8'hB5, 1'b0, Free,  8'h00, 1'b0},
    {8'h1F, 1'b0, Free,  8'h00, 1'b0},  // match
    {8'h00, 1'b0, Free,  8'h00, 1'b0},  // start code hidden in the tail
    {8'h00, 1'b0, Free,  8'h00, 1'b0},
    {8'h01, 1'b0, Free,  8'h00, 1'b0},
    {8'hB5, 1'b0, Free,  8'h00, 1'b0},
    {8'hFF, 1'b0, Free,  8'h00, 1'b0},  // tenth byte, insertion
    {8'h1B, 1'b0, Typed, 8'h1B, 1'b0},  // history invalidated, no match
    {8'h00, 1'b0, Free,  8'h00, 1'b0},
    {8'h00, 1'b0, Free,  8'h00, 1'b0},
    {8'h01, 1'b0, Free,  8'h00, 1'b0},
    {8'hB5, 1'b0, Free,  8'h00, 1'b0},
    {8'h10, 1'b1, Typed, 8'h10, 1'b1},  // extension cut short at once
    {8'h00, 1'b0, Free,  8'h00, 1'b0},
    {8'h00, 1'b0, Free,  8'h00, 1'b0},
    {8'h01, 1'b0, Free,  8'h00, 1'b0},
    {8'hB5, 1'b0, Free,  8'h00, 1'b0},
    {8'h1A, 1'b0, Free,  8'h00, 1'b0},
    {8'h80, 1'b0, Free,  8'h00, 1'b0},
    {8'h7F, 1'b0, Free,  8'h00, 1'b0},
    {8'h55, 1'b0, Free,  8'h00, 1'b0},
    {8'hAA, 1'b0, Free,  8'h00, 1'b0},
    {8'h01, 1'b1, Free,  8'h00, 1'b0}   // tenth byte ends the stream
  };

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  mpeg2_seq_ext_inserter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: scan history, its fill level and the extension tail.
  // --------------------------------------------------------------------------
  logic [7:0]         scan_hist [HistDepth];
  logic [HistCntW-1:0] scan_fill;
  logic [ExtRemW-1:0]  tail_left;

  out_word_t stream_q [$];   // output words still owed by the block
  int n_words_in;
  int n_words_out;
  int n_inserts;
  int n_stream_ends;
  int n_errors;

  function automatic void clear_scan();
    foreach (scan_hist[k]) scan_hist[k] = 8'h00;
    scan_fill = '0;
    tail_left = '0;
  endfunction

  // Forecast the output words of one accepted input word and queue them.
  function automatic void forecast_words(input in_word_t w);
    out_word_t res [$];
    out_word_t tail_word;
    logic      hit;
    res.push_back('{out_byte: w.data_byte, out_last: 1'b0});
    if (tail_left != 0) begin
      // Inside a matched extension: count down, never scan.
      tail_left--;
      if (tail_left == 0) begin
        scan_fill = '0;
        n_inserts++;
        foreach (DispBytes[k]) res.push_back('{out_byte: DispBytes[k], out_last: 1'b0});
      end
    end else begin
      hit = (scan_fill >= HistDepth) &&
            scan_hist[0] == ScPrefix0 && scan_hist[1] == ScPrefix1 &&
            scan_hist[2] == ScPrefix2 && scan_hist[3] == ExtStartId &&
            w.data_byte[7:4] == SeqExtId;
      for (int k = 0; k < HistDepth - 1; k++) scan_hist[k] = scan_hist[k+1];
      scan_hist[HistDepth-1] = w.data_byte;
      if (hit) begin
        tail_left = ExtRemW'(SeqExtTail);
        scan_fill = '0;
      end else if (scan_fill < HistDepth) begin
        scan_fill++;
      end
    end
    if (w.is_last) begin
      // Move the end marker to the final word emitted, then start afresh.
      tail_word = res.pop_back();
      tail_word.out_last = 1'b1;
      res.push_back(tail_word);
      n_stream_ends++;
      clear_scan();
    end
    foreach (res[k]) stream_q.push_back(res[k]);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps between them. Valid is
  // only dropped at the start of a gap, so it never falls while a word waits.
  // --------------------------------------------------------------------------
  int burst_left;

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 14);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    // Hold the word until the handshake completes.
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
    n_words_in++;
    forecast_words(w);
  endtask

  // Noise byte, biased toward the bytes that make up start codes.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = ScPrefix0;
      1:       b = ScPrefix2;
      2:       b = ExtStartId;
      3:       b = {SeqExtId, 4'($urandom)};
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: a 7-phase stall mask, reshuffled for each random-length segment,
  // with all-ready stretches in between. A prime period lets stalls land on
  // every phase of a 12-word insertion. One long hold-off backs up the input.
  // --------------------------------------------------------------------------
  logic [6:0] stall_mask;
  int         mask_phase;
  int         seg_left;
  int         hold_left;
  bit         hold_req;
  bit         hold_taken;

  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       stall_mask = '1;
          1:       stall_mask = 7'($urandom);
          default: stall_mask = 7'($urandom) | 7'($urandom);
        endcase
        if (stall_mask == '0) stall_mask = 7'b0000001;
      end
      seg_left--;
      out_ready  <= stall_mask[mask_phase];
      mask_phase = (mask_phase + 1) % 7;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare every accepted output word with the oldest forecast.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_out
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      n_words_out++;
      if (stream_q.size() == 0) begin
        $error("unexpected word: out_byte %02h out_last %0b",
               out_data.out_byte, out_data.out_last);
        n_errors++;
      end else begin
        want = stream_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
          n_errors++;
        end
        if (out_data.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, out_data.out_last);
          n_errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin : stim
    in_word_t stream [$];
    in_word_t w;
    int       rand_start;
    int       target_len;
    int       nib;
    clear_scan();
    burst_left = 0;
    seg_left   = 0;
    mask_phase = 0;
    hold_left  = 0;
    hold_req   = 1'b0;
    hold_taken = 1'b0;
    n_words_in = 0;
    n_words_out = 0;
    n_inserts = 0;
    n_stream_ends = 0;
    n_errors = 0;

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; typed rows replace the forecast word.
    foreach (DirTab[r]) begin
      send_word(DirTab[r].word);
      if (DirTab[r].typed) begin
        void'(stream_q.pop_back());
        stream_q.push_back(DirTab[r].want);
      end
    end

    // Random streams. Kick off the long hold-off as they begin.
    hold_req   = 1'b1;
    rand_start = n_words_in;
    while (n_words_in - rand_start < RandWords) begin
      stream.delete();
      target_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                              : $urandom_range(6, 40);
      while (stream.size() < target_len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // Well-formed sequence extension with random content.
            stream.push_back('{ScPrefix0, 1'b0});
            stream.push_back('{ScPrefix1, 1'b0});
            stream.push_back('{ScPrefix2, 1'b0});
            stream.push_back('{ExtStartId, 1'b0});
            stream.push_back('{{SeqExtId, 4'($urandom)}, 1'b0});
            repeat (SeqExtTail) stream.push_back('{noise_byte(), 1'b0});
          end
          5, 6: begin
            // Near miss: right start code, wrong extension id.
            nib = $urandom_range(0, 14);
            if (nib >= SeqExtId) nib++;
            stream.push_back('{ScPrefix0, 1'b0});
            stream.push_back('{ScPrefix1, 1'b0});
            stream.push_back('{ScPrefix2, 1'b0});
            stream.push_back('{ExtStartId, 1'b0});
            stream.push_back('{{4'(nib), 4'($urandom)}, 1'b0});
          end
          7: begin
            // Broken prefix followed by noise.
            stream.push_back('{ScPrefix0, 1'b0});
            stream.push_back('{ScPrefix1, 1'b0});
            if ($urandom_range(0, 1)) stream.push_back('{ScPrefix2, 1'b0});
            stream.push_back('{noise_byte(), 1'b0});
          end
          default: begin
            repeat ($urandom_range(1, 6)) stream.push_back('{noise_byte(), 1'b0});
          end
        endcase
      end
      // Truncate to length, so some streams end inside an extension.
      while (stream.size() > target_len) void'(stream.pop_back());
      w = stream.pop_back();
      w.is_last = 1'b1;
      stream.push_back(w);
      foreach (stream[k]) send_word(stream[k]);
    end
    in_valid <= 1'b0;

    // Drain every owed word, then watch a little longer for strays.
    while (stream_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d input words (%0d from the table), %0d output words,",
             n_words_in, NumDirRows, n_words_out);
    $display("%0d display extensions inserted, %0d stream ends, one %0d-cycle hold-off.",
             n_inserts, n_stream_ends, HoldCycles);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(2_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
